// ----- hw/rtl/fxalu_pkg.sv -----
// Shared types, operation codes and a saturation helper for the Q24.8 fixed-point ALU.
package fxalu_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MIN = 3'd4,
    OP_MAX = 3'd5,
    OP_INC = 3'd6,
    OP_DEC = 3'd7
  } op_t;

  localparam int unsigned QBITS = 32;
  localparam int unsigned DENW  = 34;
  localparam int unsigned REMW  = DENW + QBITS;

  localparam logic [31:0] MAX32 = 32'h7fff_ffff;
  localparam logic [31:0] MIN32 = 32'h8000_0000;

  typedef struct packed {
    logic             valid;
    op_t              kind;
    logic             a_less;
    logic             a_equal;
    logic             a_greater;
    logic             neg;
    logic             done;
    logic             dsat;
    logic             ovf;
    logic             dz;
    logic [31:0]      res;
    logic [REMW-1:0]  rem;
    logic [DENW-1:0]  den;
    logic [QBITS-1:0] quo;
  } pipe_t;

  typedef struct packed {
    logic [31:0] res;
    logic        ovf;
  } sat_t;

  // Applies a sign to a magnitude and clamps to the signed 32-bit range.
  function automatic sat_t signed_sat(input logic [63:0] mag, input logic neg);
    sat_t s;
    s.ovf = 1'b0;
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        s.res = MIN32;
        s.ovf = 1'b1;
      end else begin
        s.res = ~mag[31:0] + 32'd1;
      end
    end else begin
      if (mag > 64'h0000_0000_7fff_ffff) begin
        s.res = MAX32;
        s.ovf = 1'b1;
      end else begin
        s.res = mag[31:0];
      end
    end
    return s;
  endfunction

endpackage

// ----- hw/rtl/fxalu_if.sv -----
// Valid/ready channel interfaces for operation beats and result beats.
interface fxalu_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink (input valid, kind, operand_a, operand_b, output ready);
endinterface

interface fxalu_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               a_less;
  logic               a_equal;
  logic               a_greater;
  logic               overflow;
  logic               divide_by_zero;
  modport source (output valid, result_value, a_less, a_equal, a_greater, overflow,
                  divide_by_zero, input ready);
  modport sink (input valid, result_value, a_less, a_equal, a_greater, overflow,
                divide_by_zero, output ready);
endinterface

// ----- hw/rtl/fxalu_div_stage.sv -----
// One restoring-division stage that resolves a single quotient bit.
module fxalu_div_stage #(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  fxalu_pkg::pipe_t din,
  output fxalu_pkg::pipe_t dout
);
  import fxalu_pkg::*;

  logic [REMW-1:0] shifted;
  pipe_t           dout_next;

  always_comb begin
    shifted   = REMW'(din.den) << BIT;
    dout_next = din;
    if (din.kind == OP_DIV && !din.done && !din.dsat && din.rem >= shifted) begin
      dout_next.rem      = din.rem - shifted;
      dout_next.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= dout_next.valid;
    end
    if (en) begin
      dout.kind      <= dout_next.kind;
      dout.a_less    <= dout_next.a_less;
      dout.a_equal   <= dout_next.a_equal;
      dout.a_greater <= dout_next.a_greater;
      dout.neg       <= dout_next.neg;
      dout.done      <= dout_next.done;
      dout.dsat      <= dout_next.dsat;
      dout.ovf       <= dout_next.ovf;
      dout.dz        <= dout_next.dz;
      dout.res       <= dout_next.res;
      dout.rem       <= dout_next.rem;
      dout.den       <= dout_next.den;
      dout.quo       <= dout_next.quo;
    end
  end

endmodule

// ----- hw/rtl/fixed_point_q24_8_alu.sv -----
// Top level of the pipelined Q24.8 fixed-point ALU.
// A user of this block sends one operation beat per cycle while the result side does not stall,
// and gets one result beat back for each, in order. Every operation, quick or slow, travels the
// same 35-stage pipeline: an operand stage that forms sums, comparisons, the 32x32
// magnitude product and the division dividend and divisor; a stage that rounds the product and
// checks whether the quotient is too large; 32 restoring-division stages that each settle one
// quotient bit; and a final stage that signs and saturates the quotient. The division stages set
// the depth. A stall on the result side freezes the whole pipeline, so the request side sees ready
// low in the same cycle; nothing is dropped or repeated. Comparison flags always reflect the two
// operands. Multiply and divide round half away from zero and every result saturates to the
// signed 32-bit range with overflow set; division by zero sets divide_by_zero and saturates by
// the sign of the dividend, or returns zero for a zero dividend.
module fixed_point_q24_8_alu #(
  parameter int FRACTION_BITS = 8
) (
  input logic       clk,
  input logic       rst,
  fxalu_req_if.sink   req,
  fxalu_rsp_if.source rsp
);
  import fxalu_pkg::*;

  localparam logic [63:0] HALF = (64'd1 << FRACTION_BITS) >> 1;

  logic en;

  logic signed [31:0] a;
  logic signed [31:0] b;
  logic [31:0]        mag_a;
  logic [31:0]        mag_b;
  logic [63:0]        prod;
  logic [32:0]        sum;
  logic [32:0]        diff;
  logic [32:0]        incr;
  logic [32:0]        decr;
  pipe_t              p0_next;
  pipe_t              p0;
  pipe_t              p1_next;
  pipe_t              p1;
  pipe_t              dv [0:QBITS];
  pipe_t              pf_next;
  pipe_t              pf;
  logic [63:0]        rounded;
  sat_t               sat_mul;
  sat_t               sat_div;

  // The whole pipeline moves whenever the output slot is empty or being taken.
  assign en        = !pf.valid || rsp.ready;
  assign req.ready = en;

  // Clamps a 33-bit two's complement sum to 32 bits.
  function automatic sat_t clamp33(input logic [32:0] v);
    sat_t s;
    s.ovf = v[32] != v[31];
    s.res = s.ovf ? (v[32] ? MIN32 : MAX32) : v[31:0];
    return s;
  endfunction

  // Operand stage: add, subtract, increment, decrement, min, max and division by zero finish here.
  always_comb begin
    sat_t c;
    a     = req.operand_a;
    b     = req.operand_b;
    mag_a = a[31] ? (~a + 32'd1) : a;
    mag_b = b[31] ? (~b + 32'd1) : b;
    prod  = mag_a * mag_b;
    sum   = {a[31], a} + {b[31], b};
    diff  = {a[31], a} - {b[31], b};
    incr  = {a[31], a} + 33'd1;
    decr  = {a[31], a} - 33'd1;
    c     = '0;

    p0_next           = '0;
    p0_next.valid     = req.valid;
    p0_next.kind      = op_t'(req.kind);
    p0_next.a_less    = a < b;
    p0_next.a_equal   = a == b;
    p0_next.a_greater = a > b;
    p0_next.neg       = a[31] != b[31];
    p0_next.done      = 1'b1;

    unique case (op_t'(req.kind))
      OP_ADD: c = clamp33(sum);
      OP_SUB: c = clamp33(diff);
      OP_INC: c = clamp33(incr);
      OP_DEC: c = clamp33(decr);
      OP_MIN: c.res = (a > b) ? b : a;
      OP_MAX: c.res = (a < b) ? b : a;
      OP_MUL: begin
        p0_next.done = 1'b0;
        p0_next.rem  = REMW'(prod);
      end
      OP_DIV: begin
        if (b == 32'sd0) begin
          p0_next.dz = 1'b1;
          c.ovf      = a != 32'sd0;
          c.res      = (a > 32'sd0) ? MAX32 : ((a < 32'sd0) ? MIN32 : 32'd0);
        end else begin
          // Rounded quotient is (2*|a|*2^F + |b|) / (2*|b|).
          p0_next.done = 1'b0;
          p0_next.rem  = (REMW'(mag_a) << (FRACTION_BITS + 1)) + REMW'(mag_b);
          p0_next.den  = {1'b0, mag_b, 1'b0};
        end
      end
      default: c = '0;
    endcase
    p0_next.res = c.res;
    p0_next.ovf = c.ovf;
  end

  // Second stage: finish the multiply, and flag quotients of 2^32 or more.
  always_comb begin
    rounded = (p0.rem[63:0] + HALF) >> FRACTION_BITS;
    sat_mul = signed_sat(rounded, p0.neg);
    p1_next = p0;
    if (!p0.done && p0.kind == OP_MUL) begin
      p1_next.res  = sat_mul.res;
      p1_next.ovf  = sat_mul.ovf;
      p1_next.done = 1'b1;
    end
    if (!p0.done && p0.kind == OP_DIV) begin
      p1_next.dsat = p0.rem >= {p0.den, {QBITS{1'b0}}};
    end
  end

  assign dv[0] = p1;

  for (genvar i = 0; i < QBITS; i++) begin : g_div
    fxalu_div_stage #(
      .BIT(QBITS - 1 - i)
    ) u_stage (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (dv[i]),
      .dout (dv[i+1])
    );
  end

  // Final stage: sign and saturate the quotient.
  always_comb begin
    sat_div = signed_sat(dv[QBITS].dsat ? 64'h0000_0001_0000_0000 :
                         {32'd0, dv[QBITS].quo}, dv[QBITS].neg);
    pf_next = dv[QBITS];
    if (!dv[QBITS].done && dv[QBITS].kind == OP_DIV) begin
      pf_next.res = sat_div.res;
      pf_next.ovf = sat_div.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0.valid <= 1'b0;
      p1.valid <= 1'b0;
      pf.valid <= 1'b0;
    end else if (en) begin
      p0.valid <= p0_next.valid;
      p1.valid <= p1_next.valid;
      pf.valid <= pf_next.valid;
    end
    if (en) begin
      p0[$bits(pipe_t)-2:0] <= p0_next[$bits(pipe_t)-2:0];
      p1[$bits(pipe_t)-2:0] <= p1_next[$bits(pipe_t)-2:0];
      pf[$bits(pipe_t)-2:0] <= pf_next[$bits(pipe_t)-2:0];
    end
  end

  assign rsp.valid          = pf.valid;
  assign rsp.result_value   = pf.res;
  assign rsp.a_less         = pf.a_less;
  assign rsp.a_equal        = pf.a_equal;
  assign rsp.a_greater      = pf.a_greater;
  assign rsp.overflow       = pf.ovf;
  assign rsp.divide_by_zero = pf.dz;

endmodule

// ----- hw/rtl/fxalu_checker.sv -----
// Port-level assertions for the fixed-point ALU and the bind that attaches them.
module fxalu_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] result_value,
  input logic        a_less,
  input logic        a_equal,
  input logic        a_greater,
  input logic        overflow,
  input logic        divide_by_zero
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped while stalled");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot({a_less, a_equal, a_greater}))
    else $error("comparison flags not exactly one");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && divide_by_zero |-> overflow == (result_value != 32'd0))
    else $error("divide by zero result and overflow disagree");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while pipeline stalled");

endmodule

bind fixed_point_q24_8_alu fxalu_port_checks u_fxalu_port_checks (
  .clk            (clk),
  .rst            (rst),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .result_value   (rsp.result_value),
  .a_less         (rsp.a_less),
  .a_equal        (rsp.a_equal),
  .a_greater      (rsp.a_greater),
  .overflow       (rsp.overflow),
  .divide_by_zero (rsp.divide_by_zero)
);
